### rtl/http_request_validator_top_defines.svh
// Assertion macros shared by the request validator RTL.
// No dependencies; set ASSERT_OFF to compile the checks out.
`ifndef HTTP_REQUEST_VALIDATOR_TOP_DEFINES_SVH
`define HTTP_REQUEST_VALIDATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/hrv_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and word-matching functions of the request validator.
// No dependencies.
package hrv_pkg;

   localparam int METHOD_CHARS    = 8;
   localparam int EXTENSION_CHARS = 5;

   localparam int MCOUNT_W = $clog2(METHOD_CHARS + 2);
   localparam int MIDX_W   = $clog2(METHOD_CHARS);
   localparam int ECOUNT_W = $clog2(EXTENSION_CHARS + 2);
   localparam int EIDX_W   = $clog2(EXTENSION_CHARS);

   localparam int METHOD_WORD_MAX = 7;
   localparam int EXT_WORD_MAX    = 4;
   localparam int VERSION_LEN     = 5;

   localparam logic [15:0] MAX_BYTES_RESET = 16'd1024;
   localparam logic [15:0] COUNT_SAT       = 16'hFFFF;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;

   typedef enum logic [3:0] {
      PH_METHOD     = 4'd0,
      PH_URI_FIRST  = 4'd1,
      PH_URI        = 4'd2,
      PH_VERSION    = 4'd3,
      PH_REQ_LF     = 4'd4,
      PH_LINE_START = 4'd5,
      PH_HEADER     = 4'd6,
      PH_HDR_LF     = 4'd7,
      PH_END_LF     = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      ST_GET         = 2'd0,
      ST_HEAD        = 2'd1,
      ST_NOT_ALLOWED = 2'd2,
      ST_BAD         = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CT_HTML  = 3'd0,
      CT_TEXT  = 3'd1,
      CT_JS    = 3'd2,
      CT_CSS   = 3'd3,
      CT_JPEG  = 3'd4,
      CT_PNG   = 3'd5,
      CT_GIF   = 3'd6,
      CT_FLASH = 3'd7
   } ctype_type;

   typedef logic [METHOD_CHARS-1:0][7:0]    method_chars_type;
   typedef logic [EXTENSION_CHARS-1:0][7:0] ext_chars_type;

   typedef struct packed {
      status_type  status;
      ctype_type   content_type;
      logic [15:0] path_length;
   } verdict_type;

   // Words are left-aligned: first character in the top byte.
   function automatic logic method_is(input method_chars_type chars,
                                      input logic [MCOUNT_W-1:0] count,
                                      input logic [8*METHOD_WORD_MAX-1:0] word,
                                      input logic [3:0] len);
      logic same;
      same = (32'(count) == 32'(len));
      for (int i = 0; i < METHOD_WORD_MAX; i++) begin
         if ((i < 32'(len)) && (chars[i] != word[8*(METHOD_WORD_MAX-1-i) +: 8])) begin
            same = 1'b0;
         end
      end
      return same;
   endfunction

   function automatic logic ext_is(input ext_chars_type chars,
                                   input logic [ECOUNT_W-1:0] count,
                                   input logic [8*EXT_WORD_MAX-1:0] word,
                                   input logic [2:0] len);
      logic same;
      same = (32'(count) == 32'(len));
      for (int i = 0; i < EXT_WORD_MAX; i++) begin
         if ((i < 32'(len)) && (chars[i] != word[8*(EXT_WORD_MAX-1-i) +: 8])) begin
            same = 1'b0;
         end
      end
      return same;
   endfunction

   function automatic status_type method_class(input method_chars_type chars,
                                               input logic [MCOUNT_W-1:0] count);
      status_type st;
      st = ST_BAD;
      if (32'(count) <= METHOD_CHARS) begin
         if (method_is(chars, count, {"GET", 32'h0}, 4'd3)) begin
            st = ST_GET;
         end else if (method_is(chars, count, {"HEAD", 24'h0}, 4'd4)) begin
            st = ST_HEAD;
         end else if (method_is(chars, count, {"POST", 24'h0}, 4'd4)
                   || method_is(chars, count, {"PUT", 32'h0}, 4'd3)
                   || method_is(chars, count, {"DELETE", 8'h0}, 4'd6)
                   || method_is(chars, count, "CONNECT", 4'd7)
                   || method_is(chars, count, "OPTIONS", 4'd7)
                   || method_is(chars, count, {"TRACE", 16'h0}, 4'd5)
                   || method_is(chars, count, {"PATCH", 16'h0}, 4'd5)) begin
            st = ST_NOT_ALLOWED;
         end
      end
      return st;
   endfunction

   function automatic ctype_type ext_class(input logic dot_seen,
                                           input ext_chars_type chars,
                                           input logic [ECOUNT_W-1:0] count);
      ctype_type ct;
      ct = CT_HTML;
      if (dot_seen && (32'(count) <= EXTENSION_CHARS)) begin
         if (ext_is(chars, count, {"txt", 8'h0}, 3'd3)) begin
            ct = CT_TEXT;
         end else if (ext_is(chars, count, {"js", 16'h0}, 3'd2)) begin
            ct = CT_JS;
         end else if (ext_is(chars, count, {"css", 8'h0}, 3'd3)) begin
            ct = CT_CSS;
         end else if (ext_is(chars, count, {"jpg", 8'h0}, 3'd3)
                   || ext_is(chars, count, "jpeg", 3'd4)) begin
            ct = CT_JPEG;
         end else if (ext_is(chars, count, {"png", 8'h0}, 3'd3)) begin
            ct = CT_PNG;
         end else if (ext_is(chars, count, {"gif", 8'h0}, 3'd3)) begin
            ct = CT_GIF;
         end else if (ext_is(chars, count, {"swf", 8'h0}, 3'd3)) begin
            ct = CT_FLASH;
         end
      end
      return ct;
   endfunction

   function automatic logic [7:0] version_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = "H";
         3'd1:    ch = "T";
         3'd2:    ch = "T";
         3'd3:    ch = "P";
         default: ch = CH_SLASH;
      endcase
      return ch;
   endfunction

endpackage

### rtl/http_request_validator_top.sv
`timescale 1ns / 1ps
// HTTP request line and header validator, top level.
// Depends on hrv_pkg, hrv_parser and hrv_out_queue.
//
// Request bytes enter one per clock on the req_ channel while req_stall is
// low; the parser state advances in the same cycle a byte is accepted, so
// the sustained rate is one byte per cycle when not stalled. A verdict
// (status, content type, path length) is produced at the LF of the closing
// empty line or at a byte flagged req_last_byte, and is registered into a
// two-entry result queue. req_stall is high while it holds two entries. The
// length limit is written through csr_write_enable/csr_write_data (reset
// 1024) and must only change between requests. No clearing pass runs
// after reset.
module http_request_validator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_content_type,
   output logic [15:0] rsp_path_length,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import hrv_pkg::*;

   logic        accept;
   logic        push;
   logic        full;
   verdict_type verdict;
   verdict_type head;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   hrv_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .last_byte        (req_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .verdict          (verdict)
   );

   hrv_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (verdict),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_status       = head.status;
   assign rsp_content_type = head.content_type;
   assign rsp_path_length  = head.path_length;

endmodule

### rtl/hrv_parser.sv
`timescale 1ns / 1ps
// Per-byte request parser: holds the parse state and the length limit register.
// Depends on hrv_pkg.
module hrv_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   output logic               push,
   output hrv_pkg::verdict_type verdict
);
   import hrv_pkg::*;

   phase_type                     phase_ff, phase_in;
   method_chars_type              method_chars_ff, method_chars_in;
   logic [MCOUNT_W-1:0]           method_count_ff, method_count_in;
   logic [2:0]                    version_pos_ff, version_pos_in;
   logic                          colon_seen_ff, colon_seen_in;
   logic                          error_seen_ff, error_seen_in;
   ext_chars_type                 ext_chars_ff, ext_chars_in;
   logic [ECOUNT_W-1:0]           ext_count_ff, ext_count_in;
   logic                          dot_seen_ff, dot_seen_in;
   logic [15:0]                   uri_count_ff, uri_count_in;
   logic [15:0]                   byte_count_ff, byte_count_in;
   logic [15:0]                   max_bytes_ff;
   logic [15:0]                   byte_next;
   logic                          err;
   logic                          done;
   status_type                    mclass;

   always_comb begin
      phase_in        = phase_ff;
      method_chars_in = method_chars_ff;
      method_count_in = method_count_ff;
      version_pos_in  = version_pos_ff;
      colon_seen_in   = colon_seen_ff;
      error_seen_in   = error_seen_ff;
      ext_chars_in    = ext_chars_ff;
      ext_count_in    = ext_count_ff;
      dot_seen_in     = dot_seen_ff;
      uri_count_in    = uri_count_ff;
      byte_count_in   = byte_count_ff;
      push            = 1'b0;
      done            = 1'b0;
      verdict.status       = ST_BAD;
      verdict.content_type = CT_TEXT;
      verdict.path_length  = '0;
      mclass = method_class(method_chars_ff, method_count_ff);

      byte_next = (byte_count_ff < COUNT_SAT) ? byte_count_ff + 16'd1 : byte_count_ff;
      err = error_seen_ff || (byte_next > max_bytes_ff);

      if (accept) begin
         byte_count_in = byte_next;
         if (!err) begin
            case (phase_ff)
               PH_METHOD: begin
                  if (data_byte == CH_SP) begin
                     if (method_count_ff == '0) err = 1'b1;
                     else phase_in = PH_URI_FIRST;
                  end else if ((data_byte == CH_CR) || (data_byte == CH_LF)) begin
                     err = 1'b1;
                  end else begin
                     if (32'(method_count_ff) < METHOD_CHARS) begin
                        method_chars_in[method_count_ff[MIDX_W-1:0]] = data_byte;
                     end
                     if (32'(method_count_ff) <= METHOD_CHARS) begin
                        method_count_in = method_count_ff + 1'b1;
                     end
                  end
               end
               PH_URI_FIRST: begin
                  if (data_byte != CH_SLASH) begin
                     err = 1'b1;
                  end else begin
                     uri_count_in = 16'd1;
                     phase_in     = PH_URI;
                  end
               end
               PH_URI: begin
                  if (data_byte == CH_SP) begin
                     phase_in = PH_VERSION;
                  end else if ((data_byte == CH_CR) || (data_byte == CH_LF)) begin
                     err = 1'b1;
                  end else begin
                     if (uri_count_ff < COUNT_SAT) uri_count_in = uri_count_ff + 16'd1;
                     if (data_byte == CH_DOT) begin
                        // restart the extension at every dot
                        dot_seen_in  = 1'b1;
                        ext_count_in = '0;
                     end else if (dot_seen_ff) begin
                        if (32'(ext_count_ff) < EXTENSION_CHARS) begin
                           ext_chars_in[ext_count_ff[EIDX_W-1:0]] = data_byte;
                        end
                        if (32'(ext_count_ff) <= EXTENSION_CHARS) begin
                           ext_count_in = ext_count_ff + 1'b1;
                        end
                     end
                  end
               end
               PH_VERSION: begin
                  if (32'(version_pos_ff) < VERSION_LEN) begin
                     if (data_byte != version_char(version_pos_ff)) err = 1'b1;
                     else version_pos_in = version_pos_ff + 3'd1;
                  end else if (data_byte == CH_CR) begin
                     // at least one version character must follow the slash
                     if (32'(version_pos_ff) == VERSION_LEN) err = 1'b1;
                     else phase_in = PH_REQ_LF;
                  end else if (data_byte == CH_LF) begin
                     err = 1'b1;
                  end else begin
                     version_pos_in = 3'(VERSION_LEN + 1);
                  end
               end
               PH_REQ_LF, PH_HDR_LF: begin
                  if (data_byte == CH_LF) phase_in = PH_LINE_START;
                  else err = 1'b1;
               end
               PH_LINE_START: begin
                  if (data_byte == CH_CR) begin
                     phase_in = PH_END_LF;
                  end else if (data_byte == CH_LF) begin
                     err = 1'b1;
                  end else begin
                     colon_seen_in = (data_byte == CH_COLON);
                     phase_in      = PH_HEADER;
                  end
               end
               PH_HEADER: begin
                  if (data_byte == CH_COLON) begin
                     colon_seen_in = 1'b1;
                  end else if (data_byte == CH_CR) begin
                     if (colon_seen_ff) phase_in = PH_HDR_LF;
                     else err = 1'b1;
                  end else if (data_byte == CH_LF) begin
                     err = 1'b1;
                  end
               end
               PH_END_LF: begin
                  if (data_byte == CH_LF) done = 1'b1;
                  else err = 1'b1;
               end
               default: begin
                  err = 1'b1;
               end
            endcase
         end
         if (err) done = 1'b0;
         error_seen_in = err;

         if (done || last_byte) begin
            push = 1'b1;
            if (done) begin
               verdict.status = mclass;
               if ((mclass == ST_GET) || (mclass == ST_HEAD)) begin
                  verdict.content_type = ext_class(dot_seen_ff, ext_chars_ff, ext_count_ff);
                  verdict.path_length  = uri_count_ff;
               end
            end
            // start a fresh request with the next byte
            phase_in        = PH_METHOD;
            method_count_in = '0;
            version_pos_in  = '0;
            colon_seen_in   = 1'b0;
            error_seen_in   = 1'b0;
            ext_count_in    = '0;
            dot_seen_in     = 1'b0;
            uri_count_in    = '0;
            byte_count_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_METHOD;
         method_count_ff <= '0;
         version_pos_ff  <= '0;
         colon_seen_ff   <= 1'b0;
         error_seen_ff   <= 1'b0;
         ext_count_ff    <= '0;
         dot_seen_ff     <= 1'b0;
         uri_count_ff    <= '0;
         byte_count_ff   <= '0;
         max_bytes_ff    <= MAX_BYTES_RESET;
      end else begin
         phase_ff        <= phase_in;
         method_count_ff <= method_count_in;
         version_pos_ff  <= version_pos_in;
         colon_seen_ff   <= colon_seen_in;
         error_seen_ff   <= error_seen_in;
         ext_count_ff    <= ext_count_in;
         dot_seen_ff     <= dot_seen_in;
         uri_count_ff    <= uri_count_in;
         byte_count_ff   <= byte_count_in;
         if (csr_write_enable) max_bytes_ff <= csr_write_data;
      end
   end

   // character stores are only read below their counts
   always_ff @(posedge clock) begin
      method_chars_ff <= method_chars_in;
      ext_chars_ff    <= ext_chars_in;
   end

endmodule

### rtl/hrv_out_queue.sv
`timescale 1ns / 1ps
// Two-entry result queue between the parser and the response channel.
// Depends on hrv_pkg and the assertion macro header.
`include "http_request_validator_top_defines.svh"
module hrv_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hrv_pkg::verdict_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hrv_pkg::verdict_type head
);
   import hrv_pkg::*;

   logic [1:0]  count_ff, count_in;
   verdict_type slot0_ff, slot0_in;
   verdict_type slot1_ff, slot1_in;
   logic        pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         // advance the second entry to the head
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) slot0_in = push_data;
         else slot1_in = push_data;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   `ASSERT_CLK(a_no_push_when_full, clock, reset, !(push && full))
   `ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push, count_ff == $past(count_ff) - 2'd1)
   `ASSERT_NEXT(a_push_to_empty, clock, reset, push && (count_ff == 2'd0),
                rsp_valid && (slot0_ff == $past(push_data)))

endmodule
